// ===== rtl/core/sktis_pkg.sv =====
package sktis_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int DEFAULT_KEY_BITS    = 16;
    localparam int PAYLOAD_BITS        = 52;

    typedef enum logic [2:0] {
        STATUS_INSERTED  = 3'd0,
        STATUS_DUPLICATE = 3'd1,
        STATUS_FULL      = 3'd2,
        STATUS_FOUND     = 3'd3,
        STATUS_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] key;
        logic [3:0]  kind_code;
        logic [15:0] attack_value;
        logic [15:0] defense_value;
        logic [15:0] speed_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  found_kind;
        logic [15:0] found_attack;
        logic [15:0] found_defense;
        logic [15:0] found_speed;
        logic [6:0]  entry_total;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic probe_rd;
        logic step;
        logic shift_rd;
        logic shift_hold;
        logic shift_wr;
        logic write_new;
        logic finish_ins;
        logic finish_dup;
        logic finish_full;
        logic finish_found;
        logic finish_miss;
    } cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic range_empty;
        logic hit;
        logic full;
        logic shift_more;
    } sts_t;

endpackage

// ===== rtl/core/sorted_key_table_insert_search.sv =====
// A lookup runs a binary search over the sorted table before its result is valid.
// An insert runs that search, moves each larger record up one slot and then writes the new
// record, unless the key is a duplicate or the table is full.
// Transactions are handled one at a time through the single table memory.
// A new transaction is taken once the previous result has left the output register.
// Reset (aresetn low, synchronous) empties the table and drops any pending result.
module sorted_key_table_insert_search
    import sktis_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int KEY_BITS    = DEFAULT_KEY_BITS
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    cmd_t cmd;
    sts_t sts;

    sktis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .out_busy (m_valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    sktis_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_item   (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_item  (m_data)
    );

endmodule

// ===== rtl/core/sktis_ctrl.sv =====
module sktis_ctrl
    import sktis_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  logic out_busy,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = !out_busy;
                if (in_valid && !out_busy) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (sts.range_empty) begin
                    if (sts.is_lookup) begin
                        cmd.finish_miss = 1'b1;
                        state_next      = ST_IDLE;
                    end else if (sts.full) begin
                        cmd.finish_full = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        cmd.shift_rd = 1'b1;
                        state_next   = ST_SHIFT_RD;
                    end
                end else begin
                    cmd.probe_rd = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.hit) begin
                    if (sts.is_lookup) begin
                        cmd.finish_found = 1'b1;
                    end else begin
                        cmd.finish_dup = 1'b1;
                    end
                    state_next = ST_IDLE;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_SHIFT_RD: begin
                cmd.shift_hold = 1'b1;
                state_next     = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                if (sts.shift_more) begin
                    cmd.shift_wr = 1'b1;
                    state_next   = ST_SHIFT_RD;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write_new  = 1'b1;
                cmd.finish_ins = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load |-> state_reg == ST_IDLE))
        else $error("load outside idle");
    a_one_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.finish_ins, cmd.finish_dup, cmd.finish_full,
                  cmd.finish_found, cmd.finish_miss}))
        else $error("multiple finishes");
    a_load_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load |=> state_reg == ST_PROBE))
        else $error("load did not start search");
`endif

endmodule

// ===== rtl/core/sktis_dp.sv =====
module sktis_dp
    import sktis_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int KEY_BITS    = DEFAULT_KEY_BITS
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  in_item,
    input  cmd_t      cmd,
    output sts_t      sts,
    input  logic      out_ready,
    output logic      out_valid,
    output out_item_t out_item
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = KEY_BITS + PAYLOAD_BITS;

    logic [EW-1:0] mem [TABLE_DEPTH];
    logic [EW-1:0] rd_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] lo_reg, hi_reg, pos_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic op_reg;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic [CW-1:0] mid;
    logic [IW-1:0] rd_addr;
    logic [KEY_BITS-1:0] rd_key;
    logic [CW-1:0] total_next;
    logic finish_any;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_key = rd_reg[EW-1 -: KEY_BITS];

    always_comb begin
        rd_addr = '0;
        if (cmd.probe_rd) begin
            rd_addr = mid[IW-1:0];
        end
        if (cmd.shift_hold) begin
            rd_addr = IW'(pos_reg - CW'(1));
        end
        if (cmd.shift_rd) begin
            rd_addr = IW'(count_reg - CW'(1));
        end
        if (cmd.shift_wr) begin
            rd_addr = IW'(pos_reg - CW'(2));
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= mem[rd_addr];
        if (cmd.shift_wr) begin
            mem[pos_reg[IW-1:0]] <= rd_reg;
        end
        if (cmd.write_new) begin
            mem[pos_reg[IW-1:0]] <= {key_reg, pay_reg};
        end
    end

    assign sts.is_lookup   = op_reg;
    assign sts.range_empty = !(lo_reg < hi_reg);
    assign sts.hit         = (rd_key == key_reg);
    assign sts.full        = (count_reg == CW'(TABLE_DEPTH));
    assign sts.shift_more  = (pos_reg != '0) && (rd_key > key_reg);

    assign total_next = count_reg + CW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '0;
            hi_reg <= '0;
        end else begin
            if (cmd.load) begin
                op_reg  <= in_item.operation;
                key_reg <= KEY_BITS'(in_item.key);
                pay_reg <= {in_item.kind_code, in_item.attack_value,
                            in_item.defense_value, in_item.speed_value};
                lo_reg  <= '0;
                hi_reg  <= count_reg;
            end
            if (cmd.step) begin
                if (rd_key < key_reg) begin
                    lo_reg <= mid + CW'(1);
                end else begin
                    hi_reg <= mid;
                end
            end
            if (cmd.shift_rd) begin
                pos_reg <= count_reg;
            end
            if (cmd.shift_wr) begin
                pos_reg <= pos_reg - CW'(1);
            end
        end
    end

    assign finish_any = cmd.finish_ins || cmd.finish_dup || cmd.finish_full ||
                        cmd.finish_found || cmd.finish_miss;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (finish_any) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish_ins) begin
                count_reg <= total_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        out_next = out_reg;
        if (finish_any) begin
            out_next = '0;
            out_next.entry_total = 7'(cmd.finish_ins ? total_next : count_reg);
            if (cmd.finish_ins)  out_next.status = STATUS_INSERTED;
            if (cmd.finish_dup)  out_next.status = STATUS_DUPLICATE;
            if (cmd.finish_full) out_next.status = STATUS_FULL;
            if (cmd.finish_miss) out_next.status = STATUS_NOT_FOUND;
            if (cmd.finish_found) begin
                out_next.status        = STATUS_FOUND;
                out_next.found_kind    = rd_reg[51:48];
                out_next.found_attack  = rd_reg[47:32];
                out_next.found_defense = rd_reg[31:16];
                out_next.found_speed   = rd_reg[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("count overflow");
    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_reg <= hi_reg + CW'(1))
        else $error("search range inverted");
    a_no_ins_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish_ins |-> !sts.full)
        else $error("insert into full table");
`endif

endmodule

// ===== verif/tb_sorted_key_table_insert_search.sv =====
module tb_sorted_key_table_insert_search;
    import sktis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 2000000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    sorted_key_table_insert_search u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    logic [15:0] tbl_key [DEPTH];
    logic [51:0] tbl_rec [DEPTH];
    int          tbl_count = 0;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int        error_count = 0;
    int        sent_count = 0;
    int        result_count = 0;
    int        found_count = 0;
    int        full_count = 0;
    int        dup_count = 0;
    int        send_gap = 0;
    int        recv_gap = 0;
    bit        stim_done = 1'b0;
    bit        in_taken = 1'b0;
    int        drain_at = -1;
    longint    cycle_count = 0;

    function automatic out_item_t table_apply(in_item_t it);
        out_item_t r;
        int lo;
        int hi;
        int mid;
        int slot;
        int i;
        bit hit;
        r = '0;
        lo = 0;
        hi = tbl_count;
        hit = 1'b0;
        slot = 0;
        while (lo < hi && !hit) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_key[mid] == it.key) begin
                hit = 1'b1;
                slot = mid;
            end else if (tbl_key[mid] < it.key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        if (it.operation == OP_INSERT) begin
            if (hit) begin
                r.status = STATUS_DUPLICATE;
            end else if (tbl_count >= DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                i = tbl_count;
                while (i > 0 && tbl_key[i-1] > it.key) begin
                    tbl_key[i] = tbl_key[i-1];
                    tbl_rec[i] = tbl_rec[i-1];
                    i--;
                end
                tbl_key[i] = it.key;
                tbl_rec[i] = {it.kind_code, it.attack_value, it.defense_value,
                              it.speed_value};
                tbl_count++;
                r.status = STATUS_INSERTED;
            end
        end else if (hit) begin
            r.status = STATUS_FOUND;
            {r.found_kind, r.found_attack, r.found_defense, r.found_speed} = tbl_rec[slot];
        end else begin
            r.status = STATUS_NOT_FOUND;
        end
        r.entry_total = 7'(tbl_count);
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic in_item_t make_item(bit op, logic [15:0] k, logic [3:0] kind,
                                           logic [15:0] a, logic [15:0] d, logic [15:0] s);
        in_item_t it;
        it.operation = op;
        it.key = k;
        it.kind_code = kind;
        it.attack_value = a;
        it.defense_value = d;
        it.speed_value = s;
        return it;
    endfunction

    function automatic in_item_t rand_item(bit op, logic [15:0] k);
        return make_item(op, k, 4'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
    endfunction

    logic [15:0] used_keys[$];

    function automatic logic [15:0] pick_key();
        if (used_keys.size() > 0 && $urandom_range(0, 1)) begin
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        end
        return 16'($urandom);
    endfunction

    initial begin
        logic [15:0] k;
        pending_items.push_back(make_item(OP_LOOKUP, 16'h0000, 4'h0, 16'h0, 16'h0, 16'h0));
        pending_items.push_back(make_item(OP_INSERT, 16'h8000, 4'd8, 16'hFFFF, 16'h0000,
                                          16'hFFFF));
        pending_items.push_back(make_item(OP_INSERT, 16'h0000, 4'd0, 16'h0000, 16'hFFFF,
                                          16'h0000));
        pending_items.push_back(make_item(OP_INSERT, 16'hFFFF, 4'd15, 16'hAAAA, 16'h5555,
                                          16'h1234));
        pending_items.push_back(make_item(OP_INSERT, 16'h8000, 4'd3, 16'h1, 16'h2, 16'h3));
        pending_items.push_back(make_item(OP_INSERT, 16'h4000, 4'd9, 16'h5555, 16'hAAAA,
                                          16'hFFFF));
        pending_items.push_back(make_item(OP_LOOKUP, 16'h0000, 4'hF, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF));
        pending_items.push_back(make_item(OP_LOOKUP, 16'hFFFF, 4'h0, 16'h0, 16'h0, 16'h0));
        pending_items.push_back(make_item(OP_LOOKUP, 16'h8000, 4'h0, 16'h0, 16'h0, 16'h0));
        pending_items.push_back(make_item(OP_LOOKUP, 16'h4000, 4'h0, 16'h0, 16'h0, 16'h0));
        pending_items.push_back(make_item(OP_LOOKUP, 16'h7FFF, 4'h0, 16'h0, 16'h0, 16'h0));
        pending_items.push_back(make_item(OP_INSERT, 16'h7FFF, 4'd7, 16'h0, 16'h0, 16'h0));
        pending_items.push_back(make_item(OP_LOOKUP, 16'h7FFF, 4'h0, 16'h0, 16'h0, 16'h0));
        used_keys = '{16'h0000, 16'h4000, 16'h7FFF, 16'h8000, 16'hFFFF};
        // fill past capacity with random keys
        for (int i = 0; i < 70; i++) begin
            k = 16'($urandom_range(0, 65535));
            used_keys.push_back(k);
            pending_items.push_back(rand_item(OP_INSERT, k));
        end
        for (int i = 0; i < 220; i++) begin
            pending_items.push_back(rand_item($urandom_range(0, 3) == 0 ? OP_INSERT
                                              : OP_LOOKUP, pick_key()));
        end
        pending_items.push_back(rand_item(OP_INSERT, used_keys[3]));
        pending_items.push_back(rand_item(OP_INSERT, 16'h1357));
        wait (aresetn);
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        // mix random operations on the full table
        for (int i = 0; i < 300; i++) begin
            pending_items.push_back(rand_item($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP,
                                              pick_key()));
        end
        wait (pending_items.size() == 0);
        stim_done = 1'b1;
    end

    always @(negedge aclk) begin
        bit taken;
        taken = in_taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (taken) begin
                in_taken = 1'b0;
                void'(pending_items.pop_front());
                send_gap = pick_gap();
            end
            if (!s_valid || taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0 && !(sent_count == 13 &&
                             expected_results.size() > 0)) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t exp_r;
        cycle_count++;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                exp_r = table_apply(s_data);
                expected_results.push_back(exp_r);
                sent_count++;
                in_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                result_count++;
                if (m_data.status == STATUS_FOUND) found_count++;
                if (m_data.status == STATUS_FULL) full_count++;
                if (m_data.status == STATUS_DUPLICATE) dup_count++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result %p", $time, m_data);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_data !== exp_r) begin
                        error_count++;
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r,
                                 m_data);
                    end
                end
            end
        end
        if (stim_done && expected_results.size() == 0 && drain_at < 0) begin
            drain_at = int'(cycle_count);
        end
        if (drain_at >= 0 && cycle_count >= drain_at + 200) begin
            $display("Ran %0d transactions, %0d found, %0d duplicate, %0d full",
                     sent_count, found_count, dup_count, full_count);
            if (error_count == 0 && expected_results.size() == 0) begin
                $display("sorted_key_table_insert_search verification clean");
            end else begin
                $display("sorted_key_table_insert_search verification failed");
            end
            $finish;
        end else if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("sorted_key_table_insert_search verification failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

endmodule
